// ===== rtl/erip_pkg.sv =====
// package for the record-index reference parser
// holds item types, parser state, prefix tables and the per-character update functions
// no dependencies
package erip_pkg;

    localparam int unsigned IDX_MAX = 65535;
    localparam int unsigned NUM_PFX = 3;
    localparam int unsigned PFX_SLOTS = 16;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_item_t;

    typedef struct packed {
        logic        valid_res;
        logic [15:0] index;
    } result_t;

    typedef struct packed {
        logic        body_started;
        logic        pending_space;
        logic [3:0]  prefix_position;
        logic [2:0]  prefix_alive_mask;
        logic        prefix_complete;
        logic        run_closed;
        logic        token_nonempty;
        logic [15:0] decimal_acc;
        logic        decimal_overflow;
        logic        only_digits;
        logic [15:0] base32_acc;
        logic        base32_bad;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        body_started:      1'b0,
        pending_space:     1'b0,
        prefix_position:   4'd0,
        prefix_alive_mask: 3'b111,
        prefix_complete:   1'b0,
        run_closed:        1'b0,
        token_nonempty:    1'b0,
        decimal_acc:       16'd0,
        decimal_overflow:  1'b0,
        only_digits:       1'b1,
        base32_acc:        16'd0,
        base32_bad:        1'b0
    };

    // lower-case prefix text: long embed form, flow form, short embed form
    localparam logic [7:0] PFX_TEXT [NUM_PFX][PFX_SLOTS] = '{
        '{8'h6b, 8'h69, 8'h6e, 8'h64, 8'h6c, 8'h65, 8'h3a, 8'h65,
          8'h6d, 8'h62, 8'h65, 8'h64, 8'h3a, 8'h00, 8'h00, 8'h00},
        '{8'h6b, 8'h69, 8'h6e, 8'h64, 8'h6c, 8'h65, 8'h3a, 8'h66,
          8'h6c, 8'h6f, 8'h77, 8'h3a, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h65, 8'h6d, 8'h62, 8'h65, 8'h64, 8'h3a, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] PFX_LEN [NUM_PFX] = '{4'd13, 4'd12, 4'd6};

    function automatic logic is_ws(logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_upper(logic [7:0] c);
        return c >= 8'h41 && c <= 8'h5a;
    endfunction

    function automatic logic is_lower(logic [7:0] c);
        return c >= 8'h61 && c <= 8'h7a;
    endfunction

    function automatic logic is_alnum(logic [7:0] c);
        return is_digit(c) || is_upper(c) || is_lower(c);
    endfunction

    function automatic parse_state_t clear_token(parse_state_t s);
        parse_state_t r;
        r = s;
        r.token_nonempty   = 1'b0;
        r.decimal_acc      = '0;
        r.decimal_overflow = 1'b0;
        r.only_digits      = 1'b1;
        r.base32_acc       = '0;
        r.base32_bad       = 1'b0;
        return r;
    endfunction

    function automatic parse_state_t feed_token(parse_state_t s, logic [7:0] c);
        parse_state_t r;
        logic [20:0]  dec_sum;
        logic [20:0]  b32_sum;
        logic [4:0]   digit;
        logic         b32_ok;
        r = s;
        r.token_nonempty = 1'b1;
        // times ten as shift-add
        dec_sum = {2'b00, s.decimal_acc, 3'b000} + {4'b0000, s.decimal_acc, 1'b0}
                  + {17'd0, c[3:0]};
        if (s.only_digits) begin
            if (is_digit(c)) begin
                if (!s.decimal_overflow) begin
                    if (dec_sum > 21'(IDX_MAX)) begin
                        r.decimal_overflow = 1'b1;
                    end
                    else begin
                        r.decimal_acc = dec_sum[15:0];
                    end
                end
            end
            else begin
                r.only_digits = 1'b0;
            end
        end
        b32_ok = 1'b1;
        digit  = '0;
        if (is_digit(c)) begin
            digit = {1'b0, c[3:0]};
        end
        else if ((c >= 8'h41 && c <= 8'h56) || (c >= 8'h61 && c <= 8'h76)) begin
            // letters a..v: low five bits run 1..22, digit is that plus nine
            digit = c[4:0] + 5'd9;
        end
        else begin
            b32_ok = 1'b0;
        end
        b32_sum = {s.base32_acc, 5'b00000} + {16'd0, digit};
        if (!s.base32_bad) begin
            if (!b32_ok || b32_sum > 21'(IDX_MAX)) begin
                r.base32_bad = 1'b1;
            end
            else begin
                r.base32_acc = b32_sum[15:0];
            end
        end
        return r;
    endfunction

    function automatic parse_state_t feed_body(parse_state_t s, logic [7:0] c);
        parse_state_t r;
        logic [7:0]   lc;
        logic [2:0]   alive;
        logic [3:0]   pos_n;
        r = s;
        alive = '0;
        lc = is_upper(c) ? (c | 8'h20) : c;
        pos_n = (s.prefix_position < 4'd15) ? s.prefix_position + 4'd1 : s.prefix_position;
        if (s.prefix_complete) begin
            if (!s.run_closed && is_alnum(c)) begin
                r = feed_token(s, c);
            end
            else begin
                r.run_closed = 1'b1;
            end
        end
        else begin
            r = feed_token(s, c);
            if (s.prefix_alive_mask != 3'b000) begin
                for (int p = 0; p < NUM_PFX; p++) begin
                    if (s.prefix_alive_mask[p] && s.prefix_position < PFX_LEN[p]
                        && PFX_TEXT[p][s.prefix_position] == lc) begin
                        alive[p] = 1'b1;
                    end
                end
                r.prefix_position = pos_n;
                for (int p = 0; p < NUM_PFX; p++) begin
                    if (alive[p] && PFX_LEN[p] == pos_n) begin
                        r.prefix_complete = 1'b1;
                        r = clear_token(r);
                    end
                end
                r.prefix_alive_mask = alive;
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/embed_ref_index_parser.sv =====
// top level of the record-index reference parser
// input register, per-character state update, result register
// depends on erip_pkg
//
// a final character's result is offered once the character has left the input register
// and its result has been loaded into the result register
// throughput: one character per cycle while the input does not stall, set by the combinational state update
// a result waiting on result_stall holds back only a following final character
// reset: rst_n clears the pipeline valids and returns the parser state to its
// start values; a new value may begin in the first cycle after reset
module embed_ref_index_parser
    import erip_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  char_item_t char_item,
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result
);

    // input register
    logic         s1_valid_reg;
    char_item_t   s1_item_reg;

    // parser state carried between characters of one value
    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t after_space;

    // result register
    logic         res_valid_reg;
    result_t      res_reg;
    result_t      res_next;

    logic         res_free;
    logic         s1_go;
    logic         ok;

    // the result slot is free when empty or being taken this cycle
    assign res_free = !res_valid_reg || !result_stall;

    // characters that are not final always move on; a final one needs the slot
    assign s1_go = s1_valid_reg && (!s1_item_reg.last || res_free);

    // input register takes a new item whenever its content moves on
    assign char_stall = s1_valid_reg && !s1_go;

    always_comb
    begin
        // a held whitespace run acts as one space ahead of the next body char
        after_space = state_reg;
        state_next  = state_reg;
        if (is_ws(s1_item_reg.ch)) begin
            if (state_reg.body_started) begin
                state_next.pending_space = 1'b1;
            end
        end
        else begin
            if (state_reg.pending_space) begin
                after_space = feed_body(state_reg, CH_SPACE);
                after_space.pending_space = 1'b0;
            end
            after_space.body_started = 1'b1;
            state_next = feed_body(after_space, s1_item_reg.ch);
        end
    end

    always_comb
    begin
        ok = 1'b0;
        if (state_next.body_started && state_next.token_nonempty) begin
            if (state_next.only_digits) begin
                ok = !state_next.decimal_overflow && (state_next.decimal_acc != 16'd0);
            end
            else begin
                ok = !state_next.decimal_overflow && !state_next.base32_bad
                     && (state_next.base32_acc != 16'd0);
            end
        end
        res_next.valid_res = ok;
        if (!ok) begin
            res_next.index = '0;
        end
        else if (state_next.only_digits) begin
            res_next.index = state_next.decimal_acc;
        end
        else begin
            res_next.index = state_next.base32_acc;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else begin
            if (!char_stall) begin
                s1_valid_reg <= char_valid;
            end
            if (s1_go && s1_item_reg.last) begin
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall) begin
                res_valid_reg <= 1'b0;
            end
            if (s1_go) begin
                // state starts over after every final character
                state_reg <= s1_item_reg.last ? STATE_RESET : state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!char_stall) begin
            s1_item_reg <= char_item;
        end
        if (s1_go && s1_item_reg.last) begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== test/tb_embed_ref_index_parser.sv =====
`timescale 1ns / 100ps
// self-checking testbench for embed_ref_index_parser: feeds attribute value text
// one character per item and checks each index result against a local predictor
// depends on erip_pkg and the embed_ref_index_parser rtl
module tb_embed_ref_index_parser;
    import erip_pkg::*;

    localparam int QUIET_LIMIT = 2000;   // cycles with no handshake before giving up
    localparam int LONG_HOLD   = 300;    // one long receiver hold-off
    localparam int HOLD_AFTER  = 30;     // results seen before the long hold-off
    localparam int CALM_TAIL   = 60;     // last queued items go out with no idling
    localparam int RANDOM_CHARS = 260;

    // queued item for the driver, or a marker that waits for all results
    typedef struct packed {
        logic       pause;
        char_item_t item;
    } feed_t;

    localparam feed_t PAUSE_MARK = '{pause: 1'b1, item: '0};

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       char_valid = 1'b0;
    logic       char_stall;
    char_item_t char_item = '0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    result_t    result;

    feed_t      char_queue[$];
    result_t    due_results[$];
    logic [7:0] draft[$];
    logic       calm = 1'b0;

    int send_gap = 0;
    int stall_left = 0;
    int long_left = 0;
    int quiet_cycles = 0;
    int chars_in = 0;
    int values_done = 0;
    int results_seen = 0;
    int results_good = 0;
    int fails = 0;

    // parser state of the predictor
    logic        seen_body;
    logic        space_held;
    int unsigned pfx_at;
    logic [2:0]  pfx_live;
    logic        pfx_matched;
    logic        token_shut;
    logic        token_seen;
    int unsigned dec_val;
    logic        dec_over;
    logic        digits_only;
    int unsigned b32_val;
    logic        b32_over;

    embed_ref_index_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_item    (char_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // the three reference prefixes: long embed form, flow form, short embed form
    function automatic string ref_prefix(int k);
        string head;
        head = "k";
        case (k)
            0:       return {head, "indle:embed:"};
            1:       return {head, "indle:flow:"};
            default: return "embed:";
        endcase
    endfunction

    function automatic logic blank_char(logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic digit_char(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic alnum_char(logic [7:0] c);
        return digit_char(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic void token_clear();
        token_seen  = 1'b0;
        dec_val     = 0;
        dec_over    = 1'b0;
        digits_only = 1'b1;
        b32_val     = 0;
        b32_over    = 1'b0;
    endfunction

    function automatic void parse_reset();
        seen_body   = 1'b0;
        space_held  = 1'b0;
        pfx_at      = 0;
        pfx_live    = 3'b111;
        pfx_matched = 1'b0;
        token_shut  = 1'b0;
        token_clear();
    endfunction

    // both readings of the token are tracked side by side
    function automatic void token_take(logic [7:0] c);
        int unsigned d;
        token_seen = 1'b1;
        if (digits_only) begin
            if (digit_char(c)) begin
                if (!dec_over) begin
                    d = dec_val * 10 + (c - 8'h30);
                    if (d > IDX_MAX)
                        dec_over = 1'b1;
                    else
                        dec_val = d;
                end
            end
            else begin
                digits_only = 1'b0;
            end
        end
        if (!b32_over) begin
            if (digit_char(c))
                d = c - 8'h30;
            else if (c >= "A" && c <= "V")
                d = c - 8'h41 + 10;
            else if (c >= "a" && c <= "v")
                d = c - 8'h61 + 10;
            else begin
                b32_over = 1'b1;
                return;
            end
            d = b32_val * 32 + d;
            if (d > IDX_MAX)
                b32_over = 1'b1;
            else
                b32_val = d;
        end
    endfunction

    function automatic void body_take(logic [7:0] c);
        logic [7:0] lc;
        logic [2:0] live;
        string      p;
        // after a prefix only the first run of letters and digits counts
        if (pfx_matched) begin
            if (!token_shut && alnum_char(c))
                token_take(c);
            else
                token_shut = 1'b1;
            return;
        end
        token_take(c);
        if (pfx_live == 3'b000)
            return;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        live = 3'b000;
        for (int k = 0; k < 3; k++) begin
            p = ref_prefix(k);
            if (pfx_live[k] && pfx_at < p.len() && p[pfx_at] == lc)
                live[k] = 1'b1;
        end
        if (pfx_at < 15)
            pfx_at++;
        for (int k = 0; k < 3; k++) begin
            p = ref_prefix(k);
            if (live[k] && p.len() == pfx_at) begin
                pfx_matched = 1'b1;
                token_clear();
            end
        end
        pfx_live = live;
    endfunction

    // one accepted character; a final character queues its expected result
    function automatic void parse_char(char_item_t it);
        result_t r;
        if (blank_char(it.ch)) begin
            if (seen_body)
                space_held = 1'b1;
        end
        else begin
            // held whitespace turned out to be internal
            if (space_held) begin
                body_take(8'h20);
                space_held = 1'b0;
            end
            seen_body = 1'b1;
            body_take(it.ch);
        end
        if (it.last) begin
            r = '0;
            if (seen_body && token_seen) begin
                if (digits_only) begin
                    if (!dec_over && dec_val != 0) begin
                        r.valid_res = 1'b1;
                        r.index     = dec_val[15:0];
                    end
                end
                else if (!dec_over && !b32_over && b32_val != 0) begin
                    r.valid_res = 1'b1;
                    r.index     = b32_val[15:0];
                end
            end
            due_results.push_back(r);
            values_done++;
            parse_reset();
        end
    endfunction

    // value text is built up in draft, then queued with last on its final byte
    function automatic void add_text(string s, bit mix_case);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (mix_case && c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
                c = c - 8'd32;
            draft.push_back(c);
        end
    endfunction

    function automatic void add_blanks(int unsigned lo, int unsigned hi);
        int unsigned r;
        repeat ($urandom_range(lo, hi)) begin
            r = $urandom_range(0, 5);
            draft.push_back(r == 0 ? 8'h20 : 8'(8 + r));
        end
    endfunction

    function automatic void add_noise(int unsigned most);
        repeat ($urandom_range(1, most))
            draft.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_decimal();
        int unsigned n;
        case ($urandom_range(0, 4))
            0:       n = $urandom_range(0, 9);
            1:       n = $urandom_range(0, 9999);
            2:       n = $urandom_range(1, 65535);
            3:       n = $urandom_range(65530, 65545);
            default: n = $urandom_range(0, 2000000);
        endcase
        if ($urandom_range(0, 5) == 0)
            add_text("00", 0);
        add_text($sformatf("%0d", n), 0);
    endfunction

    // mostly legal base-32 digits, now and then a letter past v
    function automatic void add_base32();
        string       digits;
        string       beyond;
        int unsigned r;
        digits = "0123456789abcdefghijklmnopqrstuv";
        beyond = "wxyz";
        repeat ($urandom_range(1, 4)) begin
            r = $urandom_range(0, 35);
            if (r < 32)
                add_text(digits.substr(r, r), 1);
            else
                add_text(beyond.substr(r - 32, r - 32), 1);
        end
    endfunction

    function automatic void send_value();
        feed_t f;
        if (draft.size() == 0)
            draft.push_back(8'h20);
        foreach (draft[i]) begin
            f.pause     = 1'b0;
            f.item.ch   = draft[i];
            f.item.last = (i == draft.size() - 1);
            char_queue.push_back(f);
        end
        draft.delete();
    endfunction

    // stimulus, reset and end of run
    initial
    begin
        int unsigned kind;
        int unsigned base;
        bit          paused_mid;
        string       s;
        parse_reset();

        // directed: range ends, trimming, blank-only value
        add_text("1", 0);          send_value();
        add_text("65535", 0);      send_value();
        add_text("65536", 0);      send_value();
        add_text("0", 0);          send_value();
        add_text(" \t42\r\n", 0);  send_value();
        add_text("\013\014 ", 0);  send_value();
        add_text("00400", 0);      send_value();
        // base-32: largest legal value, overflow
        add_text("1vvv", 0);       send_value();
        add_text("VVVV", 0);       send_value();
        // prefixes in mixed case, text after the run ignored
        add_text(ref_prefix(0), 1); add_text("0001?x", 0); send_value();
        add_text(ref_prefix(1), 1); add_text("7G", 0);     send_value();
        add_text(ref_prefix(2), 1); add_text("ab cd", 0);  send_value();
        // prefix with no token, prefix then a blank
        add_text(ref_prefix(2), 0); send_value();
        add_text(" embed: 5 ", 0);  send_value();
        add_text("embed:x", 0);     send_value();
        // internal whitespace, high bytes, decimal overflow
        add_text("12 34", 0);      send_value();
        add_text("ab", 0); draft.push_back(8'h80); draft.push_back(8'hff); send_value();
        add_text("99999999", 0);   send_value();
        add_text("70000a", 0);     send_value();
        // truncated long prefix is just a bad token
        s = ref_prefix(0);
        add_text(s.substr(0, 9), 0); add_text("7", 0); send_value();
        char_queue.push_back(PAUSE_MARK);

        // random: mostly prefixed or bare tokens, some noise and broken prefixes
        base = char_queue.size();
        paused_mid = 1'b0;
        while (char_queue.size() < base + RANDOM_CHARS) begin
            if (!paused_mid && char_queue.size() > base + RANDOM_CHARS / 2) begin
                char_queue.push_back(PAUSE_MARK);
                paused_mid = 1'b1;
            end
            if ($urandom_range(0, 3) == 0)
                add_blanks(1, 3);
            kind = $urandom_range(0, 19);
            s = ref_prefix($urandom_range(0, 2));
            if (kind < 8) begin
                add_text(s, 1);
                if ($urandom_range(0, 1) == 1)
                    add_decimal();
                else
                    add_base32();
                if ($urandom_range(0, 2) == 0)
                    add_noise(4);
            end
            else if (kind < 12)
                add_decimal();
            else if (kind < 15)
                add_base32();
            else if (kind == 15) begin
                add_text(s.substr(0, $urandom_range(0, s.len() - 2)), 1);
                add_base32();
            end
            else if (kind == 16)
                add_noise(8);
            else if (kind == 17) begin
                add_decimal();
                add_blanks(1, 2);
                add_base32();
            end
            else if (kind == 18)
                add_blanks(1, 4);
            else begin
                add_text(s, 1);
                add_blanks(0, 2);
                if ($urandom_range(0, 1) == 1)
                    add_base32();
            end
            if ($urandom_range(0, 3) == 0)
                add_blanks(1, 3);
            send_value();
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // drain: everything sent, nothing in flight
        while (char_queue.size() != 0 || char_valid || due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("checked %0d results (%0d recognized) from %0d values, %0d characters",
                 results_seen, results_good, values_done, chars_in);
        $display("stimulus: range ends, prefixes in mixed case, both bases, noise, stalls");
        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // driver: offers queued items, predicts on each accepted item
    always @(posedge clk or negedge rst_n)
    begin : feeder
        logic       show;
        char_item_t pick;
        feed_t      f;
        if (!rst_n) begin
            char_valid <= 1'b0;
            char_item  <= '0;
            calm       <= 1'b0;
            send_gap = 0;
        end
        else begin
            show = 1'b0;
            pick = char_item;
            if (char_valid && !char_stall) begin
                parse_char(char_item);
                chars_in++;
            end
            if (char_valid && char_stall) begin
                // stalled item stays put
                show = 1'b1;
            end
            else if (send_gap > 0) begin
                send_gap--;
            end
            else if (char_queue.size() > 0) begin
                if (char_queue[0].pause) begin
                    // hold off until every expected result has come back
                    if (due_results.size() == 0)
                        void'(char_queue.pop_front());
                end
                else if (!calm && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(0, 11);
                end
                else begin
                    f = char_queue.pop_front();
                    pick = f.item;
                    show = 1'b1;
                end
            end
            char_valid <= show;
            char_item  <= pick;
            calm       <= (char_queue.size() < CALM_TAIL);
        end
    end

    // monitor: checks results in order and drives the result stall
    always @(posedge clk or negedge rst_n)
    begin : collect
        logic    hold;
        result_t want;
        if (!rst_n) begin
            result_stall <= 1'b0;
            stall_left = 0;
            long_left = 0;
        end
        else begin
            if (result_valid && !result_stall) begin
                if (due_results.size() == 0) begin
                    $error("unexpected result: valid_res %0b, index %0d",
                           result.valid_res, result.index);
                    fails++;
                end
                else begin
                    want = due_results.pop_front();
                    if (result.valid_res !== want.valid_res) begin
                        $error("valid_res: expected %0b, got %0b",
                               want.valid_res, result.valid_res);
                        fails++;
                    end
                    if (result.index !== want.index) begin
                        $error("index: expected %0d, got %0d", want.index, result.index);
                        fails++;
                    end
                    if (want.valid_res)
                        results_good++;
                end
                results_seen++;
                // one long hold-off so the parser backs up into its input
                if (results_seen == HOLD_AFTER)
                    long_left = LONG_HOLD;
            end
            hold = 1'b0;
            if (long_left > 0) begin
                long_left--;
                hold = 1'b1;
            end
            else if (stall_left > 0) begin
                stall_left--;
                hold = 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 11);
                hold = 1'b1;
            end
            result_stall <= hold;
        end
    end

    // watchdog: a stretch with no handshake on either side means a hang
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((char_valid && !char_stall) || (result_valid && !result_stall)) begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                         quiet_cycles, due_results.size());
                $display("Some tests failed");
                $finish;
            end
            else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule

// ===== filelist.f =====
rtl/erip_pkg.sv
rtl/embed_ref_index_parser.sv
test/tb_embed_ref_index_parser.sv
